// ===== sv/espf_pkg.sv =====
// Package for the encrypted sensor packet framer: request codes, packet constants,
// AES S-box and round helpers. No dependencies.
`default_nettype none
package espf_pkg;
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_RESET = 3'd1;
    localparam logic [2:0] REQ_ACK   = 3'd2;
    localparam logic [2:0] REQ_LIVE  = 3'd3;
    localparam logic [2:0] REQ_IMU   = 3'd4;
    localparam logic [2:0] REQ_EMG   = 3'd5;

    localparam logic [7:0] TYPE_ACK  = 8'h00;
    localparam logic [7:0] TYPE_IMU  = 8'h40;
    localparam logic [7:0] TYPE_EMG  = 8'h80;
    localparam logic [7:0] TYPE_LIVE = 8'hC0;
    localparam logic [7:0] PAD_BYTE  = 8'hAA;

    localparam int PKT_LEN = 17;
    localparam int BLK_LEN = 16;
    localparam int PAYLOAD_LEN = 12;

    localparam logic [63:0] KEY_HIGH_RST = 64'h2A462D4A614E6452;
    localparam logic [63:0] KEY_LOW_RST  = 64'h67556A586E327235;

    localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [0:0] CFG_KEY_LOW  = 1'b1;

    localparam int DATA_W = 192; // 6*16 IMU words + 3*32 EMG words

    // plaintext block, byte 0 in bits 7:0
    typedef logic [127:0] t_block;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] gmul2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // next round key; key byte i in bits 8i+7:8i
    function automatic t_block key_next(input t_block k, input logic [7:0] rcon);
        t_block n;
        logic [31:0] t;
        t = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]),
             sbox(k[111:104]) ^ rcon};
        n[31:0]   = k[31:0]   ^ t;
        n[63:32]  = k[63:32]  ^ n[31:0];
        n[95:64]  = k[95:64]  ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        return n;
    endfunction

    // SubBytes, ShiftRows and optional MixColumns
    function automatic t_block aes_round(input t_block s, input logic mix);
        t_block b, o;
        logic [7:0] a0, a1, a2, a3, x;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                b[8*(j+4*c) +: 8] = sbox(s[8*(j + 4*((c + j) % 4)) +: 8]);
            end
        end
        o = b;
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = b[32*c +: 8]; a1 = b[32*c+8 +: 8];
                a2 = b[32*c+16 +: 8]; a3 = b[32*c+24 +: 8];
                x = a0 ^ a1 ^ a2 ^ a3;
                o[32*c +: 8]    = a0 ^ x ^ gmul2(a0 ^ a1);
                o[32*c+8 +: 8]  = a1 ^ x ^ gmul2(a1 ^ a2);
                o[32*c+16 +: 8] = a2 ^ x ^ gmul2(a2 ^ a3);
                o[32*c+24 +: 8] = a3 ^ x ^ gmul2(a3 ^ a0);
            end
        end
        return o;
    endfunction
endpackage
`default_nettype wire

// ===== sv/espf_front.sv =====
// Front end: accepts request items, keeps the millisecond counter, builds plaintext
// blocks and pushes them into a two-entry queue. Depends on espf_pkg.
`default_nettype none
module espf_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [espf_pkg::DATA_W-1:0]   s_axis_tdata,
    input  wire logic [2:0]                    s_axis_tuser,
    output logic                               o_q_valid,
    input  wire logic                          i_q_pop,
    output espf_pkg::t_block                   o_q_block
);
    import espf_pkg::*;

    logic [23:0] r_ms;
    t_block      r_q [2];
    logic        r_rd, r_wr;
    logic [1:0]  r_cnt;
    logic [2:0]  req;
    logic        acc, push, is_pkt;
    t_block      blk;

    assign req = s_axis_tuser;
    assign s_axis_tready = (r_cnt != 2'd2);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign is_pkt = (req == REQ_ACK) || (req == REQ_LIVE) || (req == REQ_IMU)
                 || (req == REQ_EMG);
    assign push = acc && is_pkt;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_block = r_q[r_rd];

    // build the plaintext block
    always_comb begin
        blk = '0;
        blk[31:8] = r_ms;
        case (req)
            REQ_IMU: begin
                blk[7:0] = TYPE_IMU;
                blk[127:32] = s_axis_tdata[95:0];
            end
            REQ_EMG: begin
                blk[7:0] = TYPE_EMG;
                blk[127:32] = s_axis_tdata[191:96];
            end
            REQ_LIVE: begin
                blk[7:0] = TYPE_LIVE;
                blk[127:32] = {PAYLOAD_LEN{PAD_BYTE}};
            end
            default: begin
                blk[7:0] = TYPE_ACK;
                blk[127:32] = {PAYLOAD_LEN{PAD_BYTE}};
            end
        endcase
    end

    // counter and queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms <= '0;
            r_rd <= 1'b0;
            r_wr <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (acc && req == REQ_TICK) r_ms <= r_ms + 24'd1;
            if (acc && req == REQ_RESET) r_ms <= '0;
            if (push) r_wr <= ~r_wr;
            if (i_q_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= blk;
    end
endmodule
`default_nettype wire

// ===== sv/espf_back.sv =====
// Back end: one AES round per cycle with on-the-fly key schedule, then hands the
// ciphertext to an output register that sends 16 bytes and the checksum while the
// next block encrypts. Depends on espf_pkg.
`default_nettype none
module espf_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [127:0]     i_key,
    input  wire logic             i_q_valid,
    output logic                  o_q_pop,
    input  wire espf_pkg::t_block i_q_block,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [7:0]            m_axis_tdata,
    output logic                  m_axis_tlast
);
    import espf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ENC  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]  r_st;
    logic [3:0]  r_rnd;
    logic [7:0]  r_rcon;
    t_block      r_s, r_k;
    t_block      r_o;
    logic        r_ov;
    logic [4:0]  r_idx;
    logic [7:0]  r_chk;
    t_block      kn, rs;
    t_block      key_le;
    logic        shift, out_free, load;

    // key byte 0 is the top byte of the key
    always_comb begin
        for (int i = 0; i < 16; i++) key_le[8*i +: 8] = i_key[127-8*i -: 8];
    end

    assign kn = key_next(r_k, r_rcon);
    assign rs = aes_round(r_s, r_rnd != 4'd10);
    assign o_q_pop = (r_st == ST_IDLE) && i_q_valid;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = (r_idx == 5'd16) ? r_chk : r_o[7:0];
    assign m_axis_tlast = (r_idx == 5'd16);
    assign shift = r_ov && m_axis_tready;
    assign out_free = !r_ov || (shift && r_idx == 5'd16);
    assign load = (r_st == ST_HOLD) && out_free;

    // encryption sequencing and output occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_rnd <= '0;
            r_ov <= 1'b0;
            r_idx <= '0;
        end else begin
            case (r_st)
                ST_IDLE: if (i_q_valid) begin
                    r_st <= ST_ENC;
                    r_rnd <= 4'd1;
                end
                ST_ENC: begin
                    r_rnd <= r_rnd + 4'd1;
                    if (r_rnd == 4'd10) r_st <= ST_HOLD;
                end
                ST_HOLD: if (out_free) r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
            if (load) begin
                r_ov <= 1'b1;
                r_idx <= '0;
            end else if (shift) begin
                r_idx <= r_idx + 5'd1;
                if (r_idx == 5'd16) r_ov <= 1'b0;
            end
        end
    end

    // datapath: load, round, hold the finished block
    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_s <= i_q_block ^ key_le;
                r_k <= key_le;
                r_rcon <= 8'h01;
            end
            ST_ENC: begin
                r_s <= rs ^ kn;
                r_k <= kn;
                r_rcon <= gmul2(r_rcon);
            end
            default: ;
        endcase
    end

    // output register: take the ciphertext, shift bytes out, fold the checksum
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o <= r_s;
            r_chk <= '0;
        end else if (shift && r_idx != 5'd16) begin
            r_o <= {8'h00, r_o[127:8]};
            r_chk <= r_chk ^ r_o[7:0];
        end
    end
endmodule
`default_nettype wire

// ===== sv/encrypted_sensor_packet_framer_core.sv =====
// Encrypted sensor packet framer top: key registers, front end and back end.
// Flow: an accepted packet request is written to the queue, popped with the key add,
// passed through the AES rounds and then handed off to the output register.
// Encryption of the next packet overlaps output of the current one; tick,
// reset-time and unused items yield no packet.
// Reset: synchronous active low; counter cleared, queue and output emptied, key default.
`default_nettype none
module encrypted_sensor_packet_framer_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // imu_x, imu_y, imu_z, imu_pitch, imu_roll, imu_yaw,
    // emg_mav_bits, emg_rms_bits, emg_mnf_bits (lowest first)
    input  wire logic [espf_pkg::DATA_W-1:0] s_axis_tdata,
    input  wire logic [2:0]                  s_axis_tuser,   // req_type
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [7:0]                       m_axis_tdata,   // out_byte
    output logic                             m_axis_tlast,   // last_byte
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic                        i_cfg_index,
    input  wire logic [63:0]                 i_cfg_data
);
    import espf_pkg::*;

    logic [63:0] r_key_hi, r_key_lo;
    logic        q_valid, q_pop;
    t_block      q_block;

    assign o_cfg_ready = 1'b1;

    // hold key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= KEY_HIGH_RST;
            r_key_lo <= KEY_LOW_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_KEY_HIGH) r_key_hi <= i_cfg_data;
            if (i_cfg_index == CFG_KEY_LOW) r_key_lo <= i_cfg_data;
        end
    end

    espf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_block(q_block)
    );

    espf_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key({r_key_hi, r_key_lo}),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_block(q_block),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for encrypted_sensor_packet_framer_core: drives stream requests
// and key writes, and checks every output byte against an in-bench AES framing model.
// Depends on espf_pkg and the framer RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import espf_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_WAIT = 60;
    localparam int ITEM_W = DATA_W + 3;   // {tdata, req_type}

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic         i_cfg_index;
    logic [63:0]  i_cfg_data;

    encrypted_sensor_packet_framer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // model state
    logic [63:0] key_hi_model;
    logic [63:0] key_lo_model;
    logic [23:0] ms_count;
    logic [7:0]  sbox_tab [256];
    logic [7:0]  blk [16];
    logic [7:0]  rk [176];
    logic [8:0]  pending_bytes [$];   // {last, byte}

    bit  failed;
    int  idle_cycles;
    int  rx_hold;        // long receiver stall, counted down by the receiver process
    bit  rx_random;      // random receiver gaps enabled
    int  tx_gap_max;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = xtime(a);
        end
        return p;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    // derive the substitution table: field inverse then affine map
    function automatic void build_sbox();
        logic [7:0] inv;
        for (int a = 0; a < 256; a++) begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++) begin
                if (gf_mul(8'(a), 8'(b)) == 8'h01) inv = 8'(b);
            end
            sbox_tab[a] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
                          ^ rotl8(inv, 4) ^ 8'h63;
        end
    endfunction

    // encrypt blk in place under the model key
    function automatic void aes128_encrypt();
        logic [7:0] t [4];
        logic [7:0] tmp [16];
        logic [7:0] rc, f, a0, a1, a2, a3, s;
        rc = 8'h01;
        for (int i = 0; i < 8; i++) begin
            rk[i]     = key_hi_model[56 - 8*i +: 8];
            rk[8 + i] = key_lo_model[56 - 8*i +: 8];
        end
        for (int i = 16; i < 176; i += 4) begin
            for (int j = 0; j < 4; j++) t[j] = rk[i - 4 + j];
            if ((i % 16) == 0) begin
                f = t[0];
                t[0] = sbox_tab[t[1]] ^ rc;
                t[1] = sbox_tab[t[2]];
                t[2] = sbox_tab[t[3]];
                t[3] = sbox_tab[f];
                rc = xtime(rc);
            end
            for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ t[j];
        end
        for (int i = 0; i < 16; i++) blk[i] ^= rk[i];
        for (int r = 1; r <= 10; r++) begin
            for (int i = 0; i < 16; i++) blk[i] = sbox_tab[blk[i]];
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++) tmp[j + 4*c] = blk[j + 4*((c + j) % 4)];
            for (int i = 0; i < 16; i++) blk[i] = tmp[i];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = blk[4*c]; a1 = blk[4*c+1]; a2 = blk[4*c+2]; a3 = blk[4*c+3];
                    s = a0 ^ a1 ^ a2 ^ a3;
                    blk[4*c]   = a0 ^ s ^ xtime(a0 ^ a1);
                    blk[4*c+1] = a1 ^ s ^ xtime(a1 ^ a2);
                    blk[4*c+2] = a2 ^ s ^ xtime(a2 ^ a3);
                    blk[4*c+3] = a3 ^ s ^ xtime(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) blk[i] ^= rk[16*r + i];
        end
    endfunction

    // apply one accepted request to the model and queue the packet bytes it yields
    function automatic void frame_request(input logic [ITEM_W-1:0] d);
        logic [2:0] req;
        logic [7:0] chk;
        req = d[2:0];
        if (req == REQ_TICK) begin
            ms_count = ms_count + 24'd1;
            return;
        end
        if (req == REQ_RESET) begin
            ms_count = '0;
            return;
        end
        if (req > REQ_EMG) return;
        blk[0] = (req == REQ_ACK) ? TYPE_ACK : (req == REQ_LIVE) ? TYPE_LIVE :
                 (req == REQ_IMU) ? TYPE_IMU : TYPE_EMG;
        for (int i = 0; i < 3; i++) blk[1 + i] = ms_count[8*i +: 8];
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            if (req == REQ_IMU) blk[4 + i] = d[3 + 8*i +: 8];
            else if (req == REQ_EMG) blk[4 + i] = d[99 + 8*i +: 8];
            else blk[4 + i] = PAD_BYTE;
        end
        aes128_encrypt();
        chk = 8'h00;
        for (int i = 0; i < BLK_LEN; i++) begin
            chk ^= blk[i];
            pending_bytes.push_back({1'b0, blk[i]});
        end
        pending_bytes.push_back({1'b1, chk});
    endfunction

    // request item of the given type with every data field random
    function automatic logic [ITEM_W-1:0] make_req(input logic [2:0] req);
        logic [ITEM_W-1:0] d;
        d = '0;
        d[2:0] = req;
        for (int i = 0; i < 6; i++) d[3 + 16*i +: 16] = 16'($urandom);
        for (int i = 0; i < 3; i++) d[99 + 32*i +: 32] = $urandom;
        return d;
    endfunction

    function automatic logic [ITEM_W-1:0] make_imu(input logic [15:0] w);
        logic [ITEM_W-1:0] d;
        d = make_req(REQ_IMU);
        for (int i = 0; i < 6; i++) d[3 + 16*i +: 16] = w;
        return d;
    endfunction

    function automatic logic [ITEM_W-1:0] make_emg(input logic [31:0] w);
        logic [ITEM_W-1:0] d;
        d = make_req(REQ_EMG);
        for (int i = 0; i < 3; i++) d[99 + 32*i +: 32] = w;
        return d;
    endfunction

    function automatic int rand_gap(input int max_len);
        if (max_len == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, max_len);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // offer one request, hold until accepted, then take an optional gap
    task automatic send_req(input logic [ITEM_W-1:0] d);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = d[2:0];
        s_axis_tdata  = d[ITEM_W-1:3];
        do @(posedge i_clk); while (!s_axis_tready);
        frame_request(d);
        gap = rand_gap(tx_gap_max);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_out();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait (pending_bytes.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // write one key half while the block is idle
    task automatic write_key(input logic idx, input logic [63:0] v);
        drain_out();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_KEY_HIGH) key_hi_model = v;
        else key_lo_model = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // receiver: long hold on request, random gaps when enabled
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready = 1'b0;
            rx_hold = rx_hold - 1;
        end else if (rx_random) begin
            m_axis_tready = (rand_gap(40) == 0);
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // compare each output byte with the oldest pending one
    always @(posedge i_clk) begin
        logic [8:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected out_byte %02h last_byte %0b", m_axis_tdata, m_axis_tlast);
                failed = 1'b1;
            end else begin
                want = pending_bytes.pop_front();
                if (m_axis_tdata !== want[7:0]) begin
                    $error("out_byte expected %02h actual %02h", want[7:0], m_axis_tdata);
                    failed = 1'b1;
                end
                if (m_axis_tlast !== want[8]) begin
                    $error("last_byte expected %0b actual %0b", want[8], m_axis_tlast);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("encrypted_sensor_packet_framer_core test failed");
                $finish;
            end
        end
    end

    // default key: every packet type, field extremes, counter handling, unused codes
    task automatic test_directed();
        send_req(make_req(REQ_ACK));
        send_req(make_req(REQ_LIVE));
        send_req(make_imu(16'h8000));
        send_req(make_imu(16'h7FFF));
        send_req(make_imu(16'hFFFF));
        send_req(make_imu(16'h0000));
        send_req(make_emg(32'h0000_0000));
        send_req(make_emg(32'hFFFF_FFFF));
        repeat (5) send_req(make_req(REQ_TICK));
        send_req(make_req(REQ_ACK));
        send_req(make_req(3'd6));
        send_req(make_req(3'd7));
        send_req(make_req(REQ_LIVE));
        send_req(make_req(REQ_RESET));
        send_req(make_req(REQ_EMG));
        send_req(make_req(REQ_TICK));
        send_req(make_req(REQ_IMU));
    endtask

    // key extremes and random keys
    task automatic test_keys();
        write_key(CFG_KEY_HIGH, 64'h0);
        write_key(CFG_KEY_LOW, 64'h0);
        send_req(make_req(REQ_ACK));
        send_req(make_req(REQ_IMU));
        write_key(CFG_KEY_HIGH, '1);
        write_key(CFG_KEY_LOW, '1);
        send_req(make_req(REQ_EMG));
        send_req(make_req(REQ_LIVE));
        write_key(CFG_KEY_HIGH, {$urandom, $urandom});
        write_key(CFG_KEY_LOW, {$urandom, $urandom});
    endtask

    // receiver holds off while the sender keeps offering packets
    task automatic test_backpressure();
        tx_gap_max = 0;
        rx_hold = 400;
        repeat (8) send_req(make_req(3'($urandom_range(REQ_ACK, REQ_EMG))));
        // pause until the packets all come out
        drain_out();
        tx_gap_max = 30;
    endtask

    task automatic test_random(input int n);
        int pick;
        logic [2:0] req;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) req = REQ_TICK;
            else if (pick < 40) req = REQ_RESET;
            else if (pick < 45) req = 3'($urandom_range(6, 7));
            else req = 3'($urandom_range(REQ_ACK, REQ_EMG));
            send_req(make_req(req));
            // random receiver gaps from a third of the way on; a random key write halfway
            if (k == n / 3) rx_random = 1'b1;
            if (k == n / 2) write_key(logic'($urandom_range(0, 1)), {$urandom, $urandom});
        end
    endtask

    initial begin
        failed = 1'b0;
        idle_cycles = 0;
        rx_hold = 0;
        rx_random = 1'b0;
        tx_gap_max = 30;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        key_hi_model = KEY_HIGH_RST;
        key_lo_model = KEY_LOW_RST;
        ms_count = '0;
        build_sbox();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_keys();
        test_random(80);
        rx_random = 1'b0;
        test_keys();
        rx_random = 1'b1;
        test_random(80);

        drain_out();
        if (!failed) begin
            $display("encrypted_sensor_packet_framer_core test passed");
        end else begin
            $display("encrypted_sensor_packet_framer_core test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
